// ===== rtl/rsi_pkg.sv =====
`default_nettype none

package rsi_pkg;

    localparam int FRAC_BITS = 16;

    typedef struct packed {
        logic signed [31:0] origin_x;
        logic signed [31:0] origin_y;
        logic signed [31:0] origin_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
        logic signed [31:0] center_x;
        logic signed [31:0] center_y;
        logic signed [31:0] center_z;
        logic [30:0]        sphere_radius;
        logic [15:0]        collider_tag;
    } t_ray_in;

    typedef struct packed {
        logic               hit;
        logic signed [31:0] hit_distance;
        logic signed [31:0] hit_x;
        logic signed [31:0] hit_y;
        logic signed [31:0] hit_z;
        logic [15:0]        hit_tag;
    } t_hit_out;

endpackage

`default_nettype wire

// ===== rtl/ray_sphere_intersect.sv =====
`default_nettype none

// Ray / sphere intersection, signed fixed point (Q16.16 ports).
// Input channel: i_valid / o_stall carry one t_ray_in per transfer (ray origin,
// unnormalized direction, sphere center and radius, collider tag).
// Output channel: o_valid / i_stall carry one t_hit_out per transfer: hit flag,
// near root t along the normalized ray (may be negative), the hit point and
// the tag. On a miss or a zero direction every field is zero.
// Every input transfer yields exactly one output transfer, in order.
// Throughput: one ray per cycle while the output is not stalled. The pipeline
// is made of the two square root pipelines (32 and 37 stages, one root bit
// each), the 17-stage normalizing divider, and 13 stages of multiply, sum and
// rounding.
// Reset (i_rst_n low at a clock edge) clears all valid bits; in-flight rays
// are dropped.
// While o_valid is high and i_stall is high the whole pipeline holds, the
// output word stays put and o_stall is raised toward the sender.
module ray_sphere_intersect
    import rsi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_ray_in  i_data,
    output logic     o_stall,
    output logic     o_valid,
    output t_hit_out o_data,
    input  logic     i_stall
);

    localparam int W_A    = 33;
    localparam int W_Q    = FRAC_BITS + 1;
    localparam int W_U    = FRAC_BITS + 2;
    localparam int W_P    = W_U + W_A;
    localparam int W_H2   = W_P + 2;
    localparam int W_H    = W_H2 - FRAC_BITS;
    localparam int W_HM   = W_H - 1;
    localparam int W_HL   = (W_HM + 1) / 2;
    localparam int W_HH   = W_HM - W_HL;
    localparam int W_HSQ  = 2 * W_HM;
    localparam int W_QV   = 2 * W_H;
    localparam int W_T    = W_H + 2;
    localparam int W_M    = W_U + W_T;
    localparam int W_RS   = W_M - FRAC_BITS;
    localparam int W_S    = W_RS + 1;
    localparam int HALF   = 1 << (FRAC_BITS - 1);

    localparam logic signed [W_S-1:0] SAT_MAX = W_S'(64'sh7FFF_FFFF);
    localparam logic signed [W_S-1:0] SAT_MIN = -SAT_MAX - W_S'(1);

    typedef struct packed {
        logic [2:0][31:0]    p;
        logic [2:0][W_A-1:0] a;
        logic [2:0][31:0]    dm;
        logic [2:0]          dneg;
        logic [65:0]         aa;
        logic [61:0]         rsq;
        logic [15:0]         tag;
        logic                zero;
    } t_side_len;

    typedef struct packed {
        logic [2:0][31:0]    p;
        logic [2:0][W_A-1:0] a;
        logic [65:0]         aa;
        logic [61:0]         rsq;
        logic [15:0]         tag;
        logic                zero;
        logic                dneg;
    } t_side_div;

    typedef struct packed {
        logic [2:0][31:0]    p;
        logic [2:0][W_U-1:0] u;
        logic [W_H-1:0]      h;
        logic [15:0]         tag;
        logic                hit;
    } t_side_root;

    function automatic logic [31:0] sat32(input logic signed [W_S-1:0] v);
        logic [31:0] res;
        if (v > SAT_MAX) begin
            res = 32'h7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            res = 32'h8000_0000;
        end else begin
            res = v[31:0];
        end
        return res;
    endfunction

    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = o_valid && i_stall;

    // ---------------- stage 1: differences and magnitudes
    logic signed [31:0] in_p [3];
    logic signed [31:0] in_d [3];
    logic signed [31:0] in_c [3];

    assign in_p[0] = i_data.origin_x;
    assign in_p[1] = i_data.origin_y;
    assign in_p[2] = i_data.origin_z;
    assign in_d[0] = i_data.dir_x;
    assign in_d[1] = i_data.dir_y;
    assign in_d[2] = i_data.dir_z;
    assign in_c[0] = i_data.center_x;
    assign in_c[1] = i_data.center_y;
    assign in_c[2] = i_data.center_z;

    logic                   r1_vld;
    logic signed [31:0]     r1_p    [3];
    logic signed [W_A-1:0]  r1_a    [3];
    logic [31:0]            r1_dm   [3];
    logic [2:0]             r1_dneg;
    logic [30:0]            r1_r;
    logic [15:0]            r1_tag;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r1_p[i]    <= in_p[i];
                r1_a[i]    <= W_A'(in_p[i]) - W_A'(in_c[i]);
                r1_dm[i]   <= in_d[i][31] ? 32'(-in_d[i]) : 32'(in_d[i]);
                r1_dneg[i] <= in_d[i][31];
            end
            r1_r   <= i_data.sphere_radius;
            r1_tag <= i_data.collider_tag;
        end
    end

    // ---------------- stage 2: squares
    logic                   r2_vld;
    logic [63:0]            r2_dsq  [3];
    logic [65:0]            r2_asq  [3];
    logic [61:0]            r2_rsq;
    logic signed [31:0]     r2_p    [3];
    logic signed [W_A-1:0]  r2_a    [3];
    logic [31:0]            r2_dm   [3];
    logic [2:0]             r2_dneg;
    logic [15:0]            r2_tag;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r2_dsq[i] <= r1_dm[i] * r1_dm[i];
                r2_asq[i] <= 66'(r1_a[i]) * 66'(r1_a[i]);
                r2_p[i]   <= r1_p[i];
                r2_a[i]   <= r1_a[i];
                r2_dm[i]  <= r1_dm[i];
            end
            r2_rsq  <= r1_r * r1_r;
            r2_dneg <= r1_dneg;
            r2_tag  <= r1_tag;
        end
    end

    // ---------------- stage 3: sums of squares
    logic      r3_vld;
    logic [63:0] r3_s;
    t_side_len   r3_side;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r3_s         <= r2_dsq[0] + r2_dsq[1] + r2_dsq[2];
            r3_side.aa   <= r2_asq[0] + r2_asq[1] + r2_asq[2];
            r3_side.rsq  <= r2_rsq;
            r3_side.tag  <= r2_tag;
            r3_side.dneg <= r2_dneg;
            r3_side.zero <= (r2_dm[0] == '0) && (r2_dm[1] == '0) && (r2_dm[2] == '0);
            for (int i = 0; i < 3; i++) begin
                r3_side.p[i]  <= r2_p[i];
                r3_side.a[i]  <= r2_a[i];
                r3_side.dm[i] <= r2_dm[i];
            end
        end
    end

    // ---------------- direction length
    logic        len_vld;
    logic [31:0] len_root;
    t_side_len   len_side;

    rsi_isqrt #(
        .W_IN   (64),
        .W_SIDE ($bits(t_side_len))
    ) u_len_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r3_vld),
        .i_val   (r3_s),
        .i_side  (r3_side),
        .o_valid (len_vld),
        .o_root  (len_root),
        .o_side  (len_side)
    );

    // ---------------- normalize: dm << FRAC / len, one divider per axis
    logic [31:0] div_den;
    t_side_div   div_in_side;
    t_side_div   div_out_side;
    logic        div_vld;
    logic        div_vld_y;
    logic        div_vld_z;
    logic [W_Q-1:0] quo [3];
    logic        dneg_1;
    logic        dneg_2;

    // zero direction would divide by zero; result is discarded anyway
    assign div_den = len_side.zero ? 32'd1 : len_root;

    assign div_in_side.p    = len_side.p;
    assign div_in_side.a    = len_side.a;
    assign div_in_side.aa   = len_side.aa;
    assign div_in_side.rsq  = len_side.rsq;
    assign div_in_side.tag  = len_side.tag;
    assign div_in_side.zero = len_side.zero;
    assign div_in_side.dneg = len_side.dneg[0];

    rsi_div #(
        .W_DEN  (32),
        .W_Q    (W_Q),
        .W_SIDE ($bits(t_side_div))
    ) u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (len_vld),
        .i_num   ({len_side.dm[0], FRAC_BITS'(0)}),
        .i_den   (div_den),
        .i_side  (div_in_side),
        .o_valid (div_vld),
        .o_quo   (quo[0]),
        .o_side  (div_out_side)
    );

    rsi_div #(
        .W_DEN  (32),
        .W_Q    (W_Q),
        .W_SIDE (1)
    ) u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (len_vld),
        .i_num   ({len_side.dm[1], FRAC_BITS'(0)}),
        .i_den   (div_den),
        .i_side  (len_side.dneg[1]),
        .o_valid (div_vld_y),
        .o_quo   (quo[1]),
        .o_side  (dneg_1)
    );

    rsi_div #(
        .W_DEN  (32),
        .W_Q    (W_Q),
        .W_SIDE (1)
    ) u_div_z (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (len_vld),
        .i_num   ({len_side.dm[2], FRAC_BITS'(0)}),
        .i_den   (div_den),
        .i_side  (len_side.dneg[2]),
        .o_valid (div_vld_z),
        .o_quo   (quo[2]),
        .o_side  (dneg_2)
    );

    // ---------------- stage 5: signed unit vector, products u*a
    logic signed [W_U-1:0] u_c [3];
    logic [2:0]            u_neg;

    assign u_neg = {dneg_2, dneg_1, div_out_side.dneg};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            u_c[i] = u_neg[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
        end
    end

    logic                  r5_vld;
    logic signed [W_P-1:0] r5_prod [3];
    logic signed [W_U-1:0] r5_u    [3];
    logic [2:0][31:0]      r5_p;
    logic [65:0]           r5_aa;
    logic [61:0]           r5_rsq;
    logic [15:0]           r5_tag;
    logic                  r5_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r5_prod[i] <= W_P'(u_c[i]) * W_P'($signed(div_out_side.a[i]));
                r5_u[i]    <= u_c[i];
            end
            r5_p    <= div_out_side.p;
            r5_aa   <= div_out_side.aa;
            r5_rsq  <= div_out_side.rsq;
            r5_tag  <= div_out_side.tag;
            r5_zero <= div_out_side.zero;
        end
    end

    // ---------------- stage 6: dot product
    logic                   r6_vld;
    logic signed [W_H2-1:0] r6_h2;
    logic signed [W_U-1:0]  r6_u [3];
    logic [2:0][31:0]       r6_p;
    logic [65:0]            r6_aa;
    logic [61:0]            r6_rsq;
    logic [15:0]            r6_tag;
    logic                   r6_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r6_h2   <= W_H2'(r5_prod[0]) + W_H2'(r5_prod[1]) + W_H2'(r5_prod[2]);
            r6_u    <= r5_u;
            r6_p    <= r5_p;
            r6_aa   <= r5_aa;
            r6_rsq  <= r5_rsq;
            r6_tag  <= r5_tag;
            r6_zero <= r5_zero;
        end
    end

    // ---------------- stage 7: round h to FRAC_BITS
    logic                   r7_vld;
    logic signed [W_H-1:0]  r7_h;
    logic signed [W_U-1:0]  r7_u [3];
    logic [2:0][31:0]       r7_p;
    logic [65:0]            r7_aa;
    logic [61:0]            r7_rsq;
    logic [15:0]            r7_tag;
    logic                   r7_zero;
    logic signed [W_H2-1:0] h2_rnd;

    assign h2_rnd = r6_h2 + W_H2'(HALF);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r7_h    <= W_H'(h2_rnd >>> FRAC_BITS);
            r7_u    <= r6_u;
            r7_p    <= r6_p;
            r7_aa   <= r6_aa;
            r7_rsq  <= r6_rsq;
            r7_tag  <= r6_tag;
            r7_zero <= r6_zero;
        end
    end

    // ---------------- stage 8: h*h partial products
    logic [W_H-1:0] h_abs;
    logic [W_HM-1:0] h_mag;

    assign h_abs = r7_h[W_H-1] ? W_H'(-r7_h) : W_H'(r7_h);
    assign h_mag = h_abs[W_HM-1:0];

    logic                  r8_vld;
    logic [2*W_HL-1:0]     r8_pll;
    logic [W_HL+W_HH-1:0]  r8_plh;
    logic [2*W_HH-1:0]     r8_phh;
    logic signed [W_H-1:0] r8_h;
    logic signed [W_U-1:0] r8_u [3];
    logic [2:0][31:0]      r8_p;
    logic [65:0]           r8_aa;
    logic [61:0]           r8_rsq;
    logic [15:0]           r8_tag;
    logic                  r8_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r8_pll  <= h_mag[W_HL-1:0] * h_mag[W_HL-1:0];
            r8_plh  <= h_mag[W_HL-1:0] * h_mag[W_HM-1:W_HL];
            r8_phh  <= h_mag[W_HM-1:W_HL] * h_mag[W_HM-1:W_HL];
            r8_h    <= r7_h;
            r8_u    <= r7_u;
            r8_p    <= r7_p;
            r8_aa   <= r7_aa;
            r8_rsq  <= r7_rsq;
            r8_tag  <= r7_tag;
            r8_zero <= r7_zero;
        end
    end

    // ---------------- stage 9: h*h
    logic                  r9_vld;
    logic [W_HSQ-1:0]      r9_hsq;
    logic signed [W_H-1:0] r9_h;
    logic signed [W_U-1:0] r9_u [3];
    logic [2:0][31:0]      r9_p;
    logic [65:0]           r9_aa;
    logic [61:0]           r9_rsq;
    logic [15:0]           r9_tag;
    logic                  r9_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            // cross term counted twice: shift one more
            r9_hsq  <= (W_HSQ'(r8_phh) << (2 * W_HL)) + (W_HSQ'(r8_plh) << (W_HL + 1))
                       + W_HSQ'(r8_pll);
            r9_h    <= r8_h;
            r9_u    <= r8_u;
            r9_p    <= r8_p;
            r9_aa   <= r8_aa;
            r9_rsq  <= r8_rsq;
            r9_tag  <= r8_tag;
            r9_zero <= r8_zero;
        end
    end

    // ---------------- stage 10: quarter discriminant
    logic                   r10_vld;
    logic signed [W_QV-1:0] r10_q;
    logic signed [W_H-1:0]  r10_h;
    logic signed [W_U-1:0]  r10_u [3];
    logic [2:0][31:0]       r10_p;
    logic [15:0]            r10_tag;
    logic                   r10_zero;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r10_q    <= $signed(W_QV'(r9_hsq)) + $signed(W_QV'(r9_rsq))
                        - $signed(W_QV'(r9_aa));
            r10_h    <= r9_h;
            r10_u    <= r9_u;
            r10_p    <= r9_p;
            r10_tag  <= r9_tag;
            r10_zero <= r9_zero;
        end
    end

    t_side_root     rt_in_side;
    t_side_root     rt_side;
    logic           rt_vld;
    logic [W_H-1:0] rt_root;
    logic [W_QV-1:0] q_in;

    assign q_in           = r10_q[W_QV-1] ? '0 : W_QV'(r10_q);
    assign rt_in_side.p   = r10_p;
    assign rt_in_side.u   = {r10_u[2], r10_u[1], r10_u[0]};
    assign rt_in_side.h   = r10_h;
    assign rt_in_side.tag = r10_tag;
    assign rt_in_side.hit = !r10_zero && !r10_q[W_QV-1];

    rsi_isqrt #(
        .W_IN   (W_QV),
        .W_SIDE ($bits(t_side_root))
    ) u_disc_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (r10_vld),
        .i_val   (q_in),
        .i_side  (rt_in_side),
        .o_valid (rt_vld),
        .o_root  (rt_root),
        .o_side  (rt_side)
    );

    // ---------------- stage 11: near root
    logic                  r11_vld;
    logic signed [W_T-1:0] r11_t;
    logic [2:0][W_U-1:0]   r11_u;
    logic [2:0][31:0]      r11_p;
    logic [15:0]           r11_tag;
    logic                  r11_hit;

    always_ff @(posedge i_clk) begin
        if (en) begin
            r11_t   <= -W_T'($signed(rt_side.h)) - $signed({2'b00, rt_root});
            r11_u   <= rt_side.u;
            r11_p   <= rt_side.p;
            r11_tag <= rt_side.tag;
            r11_hit <= rt_side.hit;
        end
    end

    // ---------------- stage 12: u*t
    logic                  r12_vld;
    logic signed [W_M-1:0] r12_m [3];
    logic signed [W_T-1:0] r12_t;
    logic [2:0][31:0]      r12_p;
    logic [15:0]           r12_tag;
    logic                  r12_hit;

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r12_m[i] <= W_M'($signed(r11_u[i])) * W_M'(r11_t);
            end
            r12_t   <= r11_t;
            r12_p   <= r11_p;
            r12_tag <= r11_tag;
            r12_hit <= r11_hit;
        end
    end

    // ---------------- stage 13: round the offsets
    logic                   r13_vld;
    logic signed [W_RS-1:0] r13_rs [3];
    logic signed [W_T-1:0]  r13_t;
    logic [2:0][31:0]       r13_p;
    logic [15:0]            r13_tag;
    logic                   r13_hit;
    logic signed [W_M-1:0]  m_rnd [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            m_rnd[i] = r12_m[i] + W_M'(HALF);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r13_rs[i] <= W_RS'(m_rnd[i] >>> FRAC_BITS);
            end
            r13_t   <= r12_t;
            r13_p   <= r12_p;
            r13_tag <= r12_tag;
            r13_hit <= r12_hit;
        end
    end

    // ---------------- stage 14: hit point, saturate, output register
    logic signed [W_S-1:0] pt [3];

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            pt[i] = W_S'($signed(r13_p[i])) + W_S'(r13_rs[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            if (r13_hit) begin
                o_data.hit          <= 1'b1;
                o_data.hit_distance <= sat32(W_S'(r13_t));
                o_data.hit_x        <= sat32(pt[0]);
                o_data.hit_y        <= sat32(pt[1]);
                o_data.hit_z        <= sat32(pt[2]);
                o_data.hit_tag      <= r13_tag;
            end else begin
                o_data <= '0;
            end
        end
    end

    // ---------------- valid chain
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld  <= 1'b0;
            r2_vld  <= 1'b0;
            r3_vld  <= 1'b0;
            r5_vld  <= 1'b0;
            r6_vld  <= 1'b0;
            r7_vld  <= 1'b0;
            r8_vld  <= 1'b0;
            r9_vld  <= 1'b0;
            r10_vld <= 1'b0;
            r11_vld <= 1'b0;
            r12_vld <= 1'b0;
            r13_vld <= 1'b0;
            o_valid <= 1'b0;
        end else if (en) begin
            r1_vld  <= i_valid;
            r2_vld  <= r1_vld;
            r3_vld  <= r2_vld;
            r5_vld  <= div_vld;
            r6_vld  <= r5_vld;
            r7_vld  <= r6_vld;
            r8_vld  <= r7_vld;
            r9_vld  <= r8_vld;
            r10_vld <= r9_vld;
            r11_vld <= rt_vld;
            r12_vld <= r11_vld;
            r13_vld <= r12_vld;
            o_valid <= r13_vld;
        end
    end

`ifndef SYNTHESIS
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_data.hit |-> o_data.hit_distance == '0 && o_data.hit_tag == '0
                                   && o_data.hit_x == '0)
        else $error("miss result carries nonzero fields");

    a_hold_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |-> o_stall)
        else $error("pipeline not held while output is stalled");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !r13_vld)
        else $error("valid bits survive reset");

    a_stall_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> r13_vld == $past(r13_vld) && r11_vld == $past(r11_vld))
        else $error("pipeline moved while held");

    a_div_lanes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_vld || div_vld_y || div_vld_z |-> div_vld && div_vld_y && div_vld_z)
        else $error("divider lanes out of step");
`endif

endmodule

`default_nettype wire

// ===== rtl/rsi_isqrt.sv =====
`default_nettype none

// Pipelined integer square root, one result bit per stage: floor(sqrt(i_val)).
module rsi_isqrt #(
    parameter int W_IN   = 64,
    parameter int W_SIDE = 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  logic [W_IN-1:0]       i_val,
    input  logic [W_SIDE-1:0]     i_side,
    output logic                  o_valid,
    output logic [W_IN/2-1:0]     o_root,
    output logic [W_SIDE-1:0]     o_side
);

    localparam int W_OUT = W_IN / 2;
    localparam int W_R   = W_OUT + 2;

    logic                r_vld  [W_OUT];
    logic [W_IN-1:0]     r_x    [W_OUT];
    logic [W_R-1:0]      r_rem  [W_OUT];
    logic [W_OUT-1:0]    r_root [W_OUT];
    logic [W_SIDE-1:0]   r_side [W_OUT];

    for (genvar g = 0; g < W_OUT; g++) begin : g_stage
        logic              vld_in;
        logic [W_IN-1:0]   x_in;
        logic [W_R-1:0]    rem_in;
        logic [W_OUT-1:0]  root_in;
        logic [W_SIDE-1:0] side_in;
        logic [W_R-1:0]    rem_sh;
        logic [W_R-1:0]    trial;
        logic              ge;
        logic [W_R-1:0]    n_rem;
        logic [W_OUT-1:0]  n_root;

        if (g == 0) begin : g_src
            assign vld_in  = i_valid;
            assign x_in    = i_val;
            assign rem_in  = '0;
            assign root_in = '0;
            assign side_in = i_side;
        end else begin : g_src
            assign vld_in  = r_vld[g-1];
            assign x_in    = r_x[g-1];
            assign rem_in  = r_rem[g-1];
            assign root_in = r_root[g-1];
            assign side_in = r_side[g-1];
        end

        // bring down the next two radicand bits, try root*4+1
        assign rem_sh = {rem_in[W_R-3:0], x_in[W_IN-1:W_IN-2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = rem_sh >= trial;
        assign n_rem  = ge ? rem_sh - trial : rem_sh;
        assign n_root = {root_in[W_OUT-2:0], ge};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x[g]    <= {x_in[W_IN-3:0], 2'b00};
                r_rem[g]  <= n_rem;
                r_root[g] <= n_root;
                r_side[g] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[W_OUT-1];
    assign o_root  = r_root[W_OUT-1];
    assign o_side  = r_side[W_OUT-1];

endmodule

`default_nettype wire

// ===== rtl/rsi_div.sv =====
`default_nettype none

// Pipelined restoring divider, one quotient bit per stage.
// The dividend must be below i_den * 2^W_Q.
module rsi_div #(
    parameter int W_DEN  = 32,
    parameter int W_Q    = 17,
    parameter int W_SIDE = 1
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  logic [W_DEN+W_Q-2:0]        i_num,
    input  logic [W_DEN-1:0]            i_den,
    input  logic [W_SIDE-1:0]           i_side,
    output logic                        o_valid,
    output logic [W_Q-1:0]              o_quo,
    output logic [W_SIDE-1:0]           o_side
);

    localparam int W_NUM = W_DEN + W_Q - 1;

    logic                r_vld  [W_Q];
    logic [W_NUM-1:0]    r_rem  [W_Q];
    logic [W_DEN-1:0]    r_den  [W_Q];
    logic [W_Q-1:0]      r_quo  [W_Q];
    logic [W_SIDE-1:0]   r_side [W_Q];

    for (genvar g = 0; g < W_Q; g++) begin : g_stage
        logic              vld_in;
        logic [W_NUM-1:0]  rem_in;
        logic [W_DEN-1:0]  den_in;
        logic [W_Q-1:0]    quo_in;
        logic [W_SIDE-1:0] side_in;
        logic [W_NUM-1:0]  den_sh;
        logic              ge;

        if (g == 0) begin : g_src
            assign vld_in  = i_valid;
            assign rem_in  = i_num;
            assign den_in  = i_den;
            assign quo_in  = '0;
            assign side_in = i_side;
        end else begin : g_src
            assign vld_in  = r_vld[g-1];
            assign rem_in  = r_rem[g-1];
            assign den_in  = r_den[g-1];
            assign quo_in  = r_quo[g-1];
            assign side_in = r_side[g-1];
        end

        assign den_sh = W_NUM'(den_in) << (W_Q - 1 - g);
        assign ge     = rem_in >= den_sh;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[g] <= 1'b0;
            end else if (i_en) begin
                r_vld[g] <= vld_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[g]  <= ge ? rem_in - den_sh : rem_in;
                r_den[g]  <= den_in;
                r_quo[g]  <= {quo_in[W_Q-2:0], ge};
                r_side[g] <= side_in;
            end
        end
    end

    assign o_valid = r_vld[W_Q-1];
    assign o_quo   = r_quo[W_Q-1];
    assign o_side  = r_side[W_Q-1];

endmodule

`default_nettype wire

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import rsi_pkg::*;

    localparam int LATENCY     = 99;
    localparam int HOLD_CYCLES = 400;
    localparam int CYCLE_LIMIT = 400000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_valid;
    t_ray_in  i_data;
    logic     o_stall;
    logic     o_valid;
    t_hit_out o_data;
    logic     i_stall;

    t_hit_out hit_q[$];
    int       mismatches;
    int       cycles;
    bit       no_idle;
    bit       hold_req;

    ray_sphere_intersect DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_data  (i_data),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_data  (o_data),
        .i_stall (i_stall)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic logic [63:0] isqrt128(input logic [127:0] v);
        logic [63:0] r;
        logic [63:0] c;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= v) r = c;
        end
        return r;
    endfunction

    function automatic logic [31:0] sat32(input logic signed [63:0] x);
        if (x > 64'sd2147483647) return 32'h7FFF_FFFF;
        if (x < -64'sd2147483648) return 32'h8000_0000;
        return x[31:0];
    endfunction

    // floor((x + half) / 2^FRAC_BITS)
    function automatic logic signed [63:0] round_frac(input logic signed [63:0] x);
        return (x + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic t_hit_out predict_hit(input t_ray_in r);
        t_hit_out          res;
        logic signed [63:0] p[3], cen[3], d[3], a[3], u[3];
        logic [63:0]        dm[3], am, len, quo, hm, root;
        logic [127:0]       s, aa, q;
        logic signed [63:0] h2, h, t;
        res = '0;
        p[0] = 64'(r.origin_x);  p[1] = 64'(r.origin_y);  p[2] = 64'(r.origin_z);
        d[0] = 64'(r.dir_x);     d[1] = 64'(r.dir_y);     d[2] = 64'(r.dir_z);
        cen[0] = 64'(r.center_x); cen[1] = 64'(r.center_y); cen[2] = 64'(r.center_z);
        s = '0;
        aa = '0;
        h2 = '0;
        for (int i = 0; i < 3; i++) begin
            a[i] = p[i] - cen[i];
            dm[i] = d[i] < 0 ? -d[i] : d[i];
            am = a[i] < 0 ? -a[i] : a[i];
            s = s + {64'd0, dm[i]} * {64'd0, dm[i]};
            aa = aa + {64'd0, am} * {64'd0, am};
        end
        if (s == 0) return res;
        len = isqrt128(s);
        for (int i = 0; i < 3; i++) begin
            quo = (dm[i] << FRAC_BITS) / len;
            u[i] = d[i] < 0 ? -$signed(quo) : $signed(quo);
            h2 = h2 + u[i] * a[i];
        end
        h = round_frac(h2);
        hm = h < 0 ? -h : h;
        q = {64'd0, hm} * {64'd0, hm} + {97'd0, r.sphere_radius} * {97'd0, r.sphere_radius}
            - aa;
        if (q[127]) return res;
        root = isqrt128(q);
        t = -h - $signed(root);
        res.hit          = 1'b1;
        res.hit_distance = sat32(t);
        res.hit_x        = sat32(p[0] + round_frac(u[0] * t));
        res.hit_y        = sat32(p[1] + round_frac(u[1] * t));
        res.hit_z        = sat32(p[2] + round_frac(u[2] * t));
        res.hit_tag      = r.collider_tag;
        return res;
    endfunction

    task automatic send_ray(input t_ray_in r);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_data  <= r;
        do @(posedge i_clk); while (o_stall);
        hit_q = {hit_q, predict_hit(r)};
    endtask

    function automatic logic [31:0] near_coord();
        return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
    endfunction

    function automatic t_ray_in make_ray(input logic signed [31:0] ox, oy, oz,
                                         input logic signed [31:0] dx, dy, dz,
                                         input logic signed [31:0] cx, cy, cz,
                                         input logic [31:0] rad);
        t_ray_in r;
        r.origin_x = ox; r.origin_y = oy; r.origin_z = oz;
        r.dir_x = dx;    r.dir_y = dy;    r.dir_z = dz;
        r.center_x = cx; r.center_y = cy; r.center_z = cz;
        r.sphere_radius = rad[30:0];
        r.collider_tag  = 16'($urandom_range(0, 16'hFFFF));
        return r;
    endfunction

    // ray aimed near a sphere of modest size, mostly hits
    function automatic t_ray_in aimed_ray();
        t_ray_in r;
        int      k;
        k = $urandom_range(0, 8);
        r = make_ray(near_coord(), near_coord(), near_coord(),
                     $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
                     $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
                     $signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000,
                     0, 0, 0, $urandom_range(0, 32'h0010_0000));
        r.center_x = r.origin_x + r.dir_x * k
                     + ($signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
        r.center_y = r.origin_y + r.dir_y * k
                     + ($signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
        r.center_z = r.origin_z + r.dir_z * k
                     + ($signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000);
        return r;
    endfunction

    function automatic t_ray_in noise_ray();
        t_ray_in r;
        r = make_ray($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                     $urandom, $urandom, $urandom, $urandom);
        return r;
    endfunction

    task automatic test_extremes();
        t_ray_in r;
        r = make_ray(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        r.collider_tag = 16'hFFFF;
        send_ray(r);
        r = make_ray(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                     32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        r.collider_tag = 16'h0000;
        send_ray(r);
        send_ray(make_ray(0, 0, 0, 32'h8000_0000, 0, 0, 0, 0, 0, 32'h7FFF_FFFF));
        send_ray(make_ray(32'h8000_0000, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF, 0, 0,
                          32'h7FFF_FFFF));
        send_ray(make_ray(0, 0, 0, 0, 0, 1, 0, 0, 0, 0));
        send_ray(make_ray(32'h7FFF_FFFF, 32'h8000_0000, 0, 1, 1, 1, 0, 0, 0,
                          32'h7FFF_FFFF));
    endtask

    task automatic test_special_cases();
        // zero direction never hits, even from inside the sphere
        send_ray(make_ray(0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h0010_0000));
        send_ray(make_ray(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 32'h7FFF_FFFF, 0, 0, 32'h7FFF_FFFF));
        // outside, pointing at the sphere
        send_ray(make_ray(0, 0, 0, 32'h0001_0000, 0, 0, 32'h000A_0000, 0, 0, 32'h0002_0000));
        // pointing away: both roots negative
        send_ray(make_ray(0, 0, 0, -32'sh0001_0000, 0, 0, 32'h000A_0000, 0, 0,
                          32'h0002_0000));
        // starting inside
        send_ray(make_ray(32'h0000_8000, 0, 0, 0, 32'h0003_0000, 32'h0004_0000, 0, 0, 0,
                          32'h0005_0000));
        // grazing and near-miss
        send_ray(make_ray(0, 32'h0002_0000, 0, 32'h0001_0000, 0, 0, 32'h000A_0000, 0, 0,
                          32'h0002_0000));
        send_ray(make_ray(0, 32'h0002_0001, 0, 32'h0001_0000, 0, 0, 32'h000A_0000, 0, 0,
                          32'h0002_0000));
        // plain miss
        send_ray(make_ray(0, 0, 0, 0, 32'h0001_0000, 0, 32'h0064_0000, 0, 0, 32'h0001_0000));
        // zero radius, center on the ray
        send_ray(make_ray(0, 0, 0, 32'h0001_0000, 32'h0001_0000, 0, 32'h0005_0000,
                          32'h0005_0000, 0, 0));
        // tiny direction, hit point far out so it saturates
        send_ray(make_ray(32'h7FF0_0000, 0, 0, 1, 0, 0, 32'h8000_0000, 0, 0, 32'h7FFF_FFFF));
    endtask

    task automatic test_random(input int n);
        int sel;
        for (int i = 0; i < n; i++) begin
            if (i % 250 == 0) no_idle = ($urandom_range(0, 3) == 0);
            sel = $urandom_range(0, 99);
            if (sel < 70) send_ray(aimed_ray());
            else if (sel < 85) send_ray(noise_ray());
            else send_ray(make_ray($urandom, near_coord(), $urandom, near_coord(), $urandom,
                                   near_coord(), $urandom, near_coord(), $urandom,
                                   $urandom));
        end
        no_idle = 1'b0;
    endtask

    task automatic test_backpressure();
        hold_req = 1'b1;
        no_idle  = 1'b1;
        for (int i = 0; i < 200; i++) send_ray(aimed_ray());
        no_idle = 1'b0;
    endtask

    // receiver: random stall per result, plus one long hold-off on request
    initial begin
        int n;
        i_stall = 1'b0;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req) begin
                hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                i_stall <= 1'b0;
                @(posedge i_clk);
            end
            n = no_idle ? 0 : $urandom_range(0, 4);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin
        t_hit_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (hit_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result transfer: %p", o_data);
            end else begin
                want = hit_q.pop_front();
                if (o_data.hit !== want.hit || o_data.hit_distance !== want.hit_distance ||
                    o_data.hit_x !== want.hit_x || o_data.hit_y !== want.hit_y ||
                    o_data.hit_z !== want.hit_z || o_data.hit_tag !== want.hit_tag) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch: expected hit=%0b t=%h x=%h y=%h z=%h tag=%h",
                                 want.hit, want.hit_distance, want.hit_x, want.hit_y,
                                 want.hit_z, want.hit_tag);
                        $display("          got      hit=%0b t=%h x=%h y=%h z=%h tag=%h",
                                 o_data.hit, o_data.hit_distance, o_data.hit_x,
                                 o_data.hit_y, o_data.hit_z, o_data.hit_tag);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("ray_sphere_intersect test failed");
            $finish;
        end
    end

    initial begin
        mismatches = 0;
        cycles     = 0;
        no_idle    = 1'b0;
        hold_req   = 1'b0;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_data     = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_special_cases();
        test_backpressure();
        test_random(1500);
        i_valid <= 1'b0;
        while (hit_q.size() != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0 && hit_q.size() == 0) begin
            $display("ray_sphere_intersect test passed");
        end else begin
            $display("ray_sphere_intersect test failed");
        end
        $finish;
    end

endmodule
